// ===== design/lph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lph_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int KEY_BITS  = 31;

  localparam int SLOT_BITS  = $clog2(MAX_SLOTS);
  localparam int EFF_BITS   = SLOT_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(KEY_BITS);

  // fixed field widths
  localparam int TSIZE_BITS     = 11;
  localparam int MAXK_BITS      = 10;
  localparam int SLOT_OUT_BITS  = 10;
  localparam int PROBE_OUT_BITS = 11;
  localparam int COUNT_BITS     = 10;
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [TSIZE_BITS-1:0] TSIZE_RESET = TSIZE_BITS'(1021);
  localparam logic [MAXK_BITS-1:0]  MAXK_RESET  = MAXK_BITS'(510);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic REG_MAX_KEYS   = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_ZERO = 2'd3
  } status_e;

  typedef struct packed {
    logic [TSIZE_BITS-1:0] table_size;
    logic [MAXK_BITS-1:0]  max_keys;
  } cfg_t;

  typedef struct packed {
    logic                 we;
    logic [SLOT_BITS-1:0] addr;
    logic [KEY_BITS-1:0]  data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ===== design/lph_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lph_req_if;
  import lph_pkg::*;

  logic                valid;
  logic                ready;
  logic                operation;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, operation, key, input ready);
  modport sink   (input valid, operation, key, output ready);
endinterface

interface lph_rsp_if;
  import lph_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [1:0]                status;
  logic [SLOT_OUT_BITS-1:0]  slot;
  logic [PROBE_OUT_BITS-1:0] probes;
  logic [COUNT_BITS-1:0]     key_count;

  modport source (output valid, found, status, slot, probes, key_count, input ready);
  modport sink   (input valid, found, status, slot, probes, key_count, output ready);
endinterface

`default_nettype wire

// ===== design/lph_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lph_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lph_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [lph_pkg::APB_DATA_BITS-1:0]  pwdata,
  output      logic [lph_pkg::APB_DATA_BITS-1:0]  prdata,
  output      logic                               pready,
  output      lph_pkg::cfg_t                      cfg_o
);
  import lph_pkg::*;

  logic [TSIZE_BITS-1:0] table_size_q;
  logic [MAXK_BITS-1:0]  max_keys_q;
  logic                  reg_sel;
  logic                  wr_en;

  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TSIZE_RESET;
      max_keys_q   <= MAXK_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TABLE_SIZE: table_size_q <= pwdata[TSIZE_BITS-1:0];
        REG_MAX_KEYS:   max_keys_q   <= pwdata[MAXK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TABLE_SIZE: prdata = APB_DATA_BITS'(table_size_q);
      REG_MAX_KEYS:   prdata = APB_DATA_BITS'(max_keys_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.table_size = table_size_q;
  assign cfg_o.max_keys   = max_keys_q;

endmodule

`default_nettype wire

// ===== design/lph_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder, one key bit per cycle, MSB first. done_o is high for a single
// cycle, registered together with the last remainder step, so rem_o holds the result.
module lph_mod (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [lph_pkg::KEY_BITS-1:0]   key_i,
  input  wire logic [lph_pkg::EFF_BITS-1:0]   size_i,
  output      logic                           done_o,
  output      logic [lph_pkg::SLOT_BITS-1:0]  rem_o
);
  import lph_pkg::*;

  logic                    busy_q;
  logic                    done_q;
  logic [DIV_CNT_BITS-1:0] bit_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [EFF_BITS-1:0]     size_q;
  logic [SLOT_BITS-1:0]    rem_q;
  logic [EFF_BITS-1:0]     trial;
  logic [SLOT_BITS-1:0]    rem_d;

  always_comb begin
    trial = {rem_q, key_q[KEY_BITS-1]};
    if (trial >= size_q) begin
      rem_d = SLOT_BITS'(trial - size_q);
    end else begin
      rem_d = SLOT_BITS'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        bit_q  <= '0;
        key_q  <= key_i;
        size_q <= size_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q  <= rem_d;
        key_q  <= key_q << 1;
        bit_q  <= bit_q + 1'b1;
        done_q <= (bit_q == DIV_CNT_BITS'(KEY_BITS - 1));
        if (bit_q == DIV_CNT_BITS'(KEY_BITS - 1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== design/lph_slot_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lph_slot_mem (
  input  wire logic                           clk_i,
  input  wire lph_pkg::mem_wr_t               wr_i,
  input  wire logic [lph_pkg::SLOT_BITS-1:0]  raddr_i,
  output      logic [lph_pkg::KEY_BITS-1:0]   rdata_o
);
  import lph_pkg::*;

  logic [KEY_BITS-1:0] mem [MAX_SLOTS];
  logic [KEY_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/linear_probe_hash_set.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Set of nonzero keys in a 1024-slot table, open addressing with linear probing.
// After reset the block clears every slot, one per cycle, and accepts no
// request meanwhile (register writes are taken). Each request then has the
// divider find the home-slot remainder, one key bit per cycle, and hand it
// over; the home slot is then fetched, slots are compared in turn (the next
// slot is read ahead, and a walk over every slot ends in a further probe
// step that sees the walk is complete), and the response is posted, after
// which the block is idle again and takes the next request. A zero key goes
// straight to the response step. The response sits in an output register, so
// the next request is accepted while it waits; a request that finishes while
// that register is still held waits in its response step.
// Registers: table_size at 0x0, max_keys at 0x4.
module linear_probe_hash_set (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  lph_req_if.sink                                 req,
  lph_rsp_if.source                               rsp,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lph_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [lph_pkg::APB_DATA_BITS-1:0]  pwdata,
  output      logic [lph_pkg::APB_DATA_BITS-1:0]  prdata,
  output      logic                               pready
);
  import lph_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_FETCH,
    S_PROBE,
    S_RESP
  } state_e;

  state_e               state_q;
  cfg_t                 cfg;
  logic [EFF_BITS-1:0]  eff_size;
  logic [31:0]          ts_wide;

  logic                 op_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [SLOT_BITS-1:0] idx_q;
  logic [EFF_BITS-1:0]  n_q;
  logic [SLOT_BITS-1:0] clr_q;
  logic [COUNT_BITS-1:0] held_q;

  logic                 res_found_q;
  status_e              res_status_q;
  logic [SLOT_BITS-1:0] res_slot_q;
  logic [EFF_BITS-1:0]  res_probes_q;

  logic                      out_valid_q;
  logic                      out_found_q;
  status_e                   out_status_q;
  logic [SLOT_OUT_BITS-1:0]  out_slot_q;
  logic [PROBE_OUT_BITS-1:0] out_probes_q;
  logic [COUNT_BITS-1:0]     out_count_q;

  logic                 div_start;
  logic                 div_done;
  logic [SLOT_BITS-1:0] div_rem;

  mem_wr_t              mem_wr;
  logic [SLOT_BITS-1:0] mem_raddr;
  logic [KEY_BITS-1:0]  mem_rdata;

  logic [EFF_BITS-1:0]  idx_inc;
  logic [SLOT_BITS-1:0] idx_nxt;
  logic                 visited_all;
  logic                 slot_empty;
  logic                 slot_hit;
  logic                 limit_hit;
  logic                 place;
  logic                 in_beat;
  logic                 out_free;

  lph_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // clamp table_size to 1..MAX_SLOTS
  always_comb begin
    ts_wide = 32'(cfg.table_size);
    if (ts_wide == 32'd0) begin
      eff_size = EFF_BITS'(1);
    end else if (ts_wide > 32'(MAX_SLOTS)) begin
      eff_size = EFF_BITS'(MAX_SLOTS);
    end else begin
      eff_size = EFF_BITS'(ts_wide);
    end
  end

  assign in_beat   = req.valid && req.ready;
  assign req.ready = (state_q == S_IDLE);
  assign div_start = in_beat && (req.key != '0);

  lph_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .key_i   (req.key),
    .size_i  (eff_size),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  always_comb begin
    idx_inc     = {1'b0, idx_q} + 1'b1;
    idx_nxt     = (idx_inc >= eff_size) ? '0 : idx_inc[SLOT_BITS-1:0];
    visited_all = (n_q == eff_size);
    slot_empty  = (mem_rdata == '0);
    slot_hit    = (mem_rdata == key_q);
    limit_hit   = (held_q >= cfg.max_keys) || (32'(held_q) >= 32'(eff_size)) ||
                  (held_q == COUNT_MAX);
    place       = (state_q == S_PROBE) && !visited_all && slot_empty &&
                  (op_q == OP_INSERT) && !limit_hit;
    out_free    = !out_valid_q || rsp.ready;
  end

  always_comb begin
    mem_wr.we   = 1'b0;
    mem_wr.addr = idx_q;
    mem_wr.data = key_q;
    if (state_q == S_CLEAR) begin
      mem_wr.we   = 1'b1;
      mem_wr.addr = clr_q;
      mem_wr.data = '0;
    end else if (place) begin
      mem_wr.we = 1'b1;
    end
  end

  // read ahead the next slot while the current one is compared
  assign mem_raddr = (state_q == S_FETCH) ? idx_q : idx_nxt;

  lph_slot_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SLOT_BITS'(MAX_SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_beat) begin
            op_q         <= req.operation;
            key_q        <= req.key;
            res_found_q  <= 1'b0;
            res_status_q <= (req.key == '0) ? ST_ZERO : ST_DONE;
            res_slot_q   <= '0;
            res_probes_q <= '0;
            if (req.key == '0) begin
              state_q <= S_RESP;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            idx_q   <= div_rem;
            n_q     <= '0;
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          state_q <= S_PROBE;
        end
        S_PROBE: begin
          if (visited_all) begin
            // full walk, no empty slot met
            if (op_q == OP_INSERT) begin
              res_status_q <= ST_FULL;
            end
            state_q <= S_RESP;
          end else if (slot_empty) begin
            if (op_q == OP_INSERT) begin
              if (limit_hit) begin
                res_status_q <= ST_FULL;
              end else begin
                held_q       <= held_q + 1'b1;
                res_slot_q   <= idx_q;
                res_probes_q <= (n_q == '0) ? EFF_BITS'(1) : n_q;
              end
            end
            state_q <= S_RESP;
          end else if (slot_hit) begin
            res_found_q  <= 1'b1;
            res_slot_q   <= idx_q;
            res_status_q <= (op_q == OP_INSERT) ? ST_DUP : ST_DONE;
            state_q      <= S_RESP;
          end else begin
            idx_q <= idx_nxt;
            n_q   <= n_q + 1'b1;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_found_q  <= res_found_q;
            out_status_q <= res_status_q;
            out_slot_q   <= SLOT_OUT_BITS'(res_slot_q);
            out_probes_q <= PROBE_OUT_BITS'(res_probes_q);
            out_count_q  <= held_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid     = out_valid_q;
  assign rsp.found     = out_found_q;
  assign rsp.status    = out_status_q;
  assign rsp.slot      = out_slot_q;
  assign rsp.probes    = out_probes_q;
  assign rsp.key_count = out_count_q;

endmodule

`default_nettype wire

// ===== dv/tb_linear_probe_hash_set.sv =====
`timescale 1ns / 1ps

import lph_pkg::*;

typedef struct packed {
  logic                      found;
  status_e                   status;
  logic [SLOT_OUT_BITS-1:0]  slot;
  logic [PROBE_OUT_BITS-1:0] probes;
  logic [COUNT_BITS-1:0]     key_count;
} lph_result_t;

class hash_set_scoreboard;
  logic [KEY_BITS-1:0]   slot_keys [MAX_SLOTS];
  int unsigned           held;
  logic [TSIZE_BITS-1:0] table_size;
  logic [MAXK_BITS-1:0]  max_keys;
  lph_result_t           pending_results [$];
  int unsigned           errors, n_lookups, n_inserts, n_hits, n_stored, n_dup, n_full, n_zero;

  function new();
    foreach (slot_keys[i]) slot_keys[i] = '0;
    held       = 0;
    table_size = TSIZE_RESET;
    max_keys   = MAXK_RESET;
  endfunction

  function int unsigned eff_size();
    if (table_size == 0) return 1;
    if (table_size > MAX_SLOTS) return MAX_SLOTS;
    return table_size;
  endfunction

  function void set_register(logic idx, logic [APB_DATA_BITS-1:0] value);
    if (idx == REG_TABLE_SIZE) table_size = value[TSIZE_BITS-1:0];
    else max_keys = value[MAXK_BITS-1:0];
  endfunction

  // Apply one request to the shadow table and return its response.
  function lph_result_t lookup_or_insert(logic op, logic [KEY_BITS-1:0] key);
    lph_result_t r;
    int unsigned size, idx, n, passed;
    bit          hit, placed;
    r        = '0;
    r.status = ST_DONE;
    size     = eff_size();
    hit      = 1'b0;
    if (key == '0) begin
      r.status = ST_ZERO;
    end else begin
      idx = key % size;
      for (n = 0; n < size; n++) begin
        if (slot_keys[idx] == '0) break;
        if (slot_keys[idx] == key) begin
          hit = 1'b1;
          break;
        end
        idx = (idx + 1 == size) ? 0 : idx + 1;
      end
      if (hit) begin
        r.found  = 1'b1;
        r.slot   = SLOT_OUT_BITS'(idx);
        r.status = (op == OP_INSERT) ? ST_DUP : ST_DONE;
      end else if (op == OP_INSERT) begin
        if (held >= max_keys || held >= size || held >= COUNT_MAX) begin
          r.status = ST_FULL;
        end else begin
          idx    = key % size;
          passed = 0;
          placed = 1'b0;
          for (n = 0; n < size; n++) begin
            if (slot_keys[idx] == '0) begin
              placed = 1'b1;
              break;
            end
            passed++;
            idx = (idx + 1 == size) ? 0 : idx + 1;
          end
          if (!placed) begin
            r.status = ST_FULL;
          end else begin
            slot_keys[idx] = key;
            held++;
            r.slot   = SLOT_OUT_BITS'(idx);
            r.probes = PROBE_OUT_BITS'((passed == 0) ? 1 : passed);
          end
        end
      end
    end
    r.key_count = COUNT_BITS'(held);
    return r;
  endfunction

  function void note_request(logic op, logic [KEY_BITS-1:0] key);
    lph_result_t r;
    r = lookup_or_insert(op, key);
    pending_results.push_back(r);
    if (op == OP_INSERT) n_inserts++;
    else n_lookups++;
    if (r.found) n_hits++;
    if (r.probes != 0) n_stored++;
    case (r.status)
      ST_DUP:  n_dup++;
      ST_FULL: n_full++;
      ST_ZERO: n_zero++;
      default: ;
    endcase
  endfunction

  function void check_response(lph_result_t got);
    lph_result_t want;
    if (pending_results.size() == 0) begin
      $error("response beat with no request outstanding");
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.slot !== want.slot) begin
      $error("slot: expected %0d, got %0d", want.slot, got.slot);
      errors++;
    end
    if (got.probes !== want.probes) begin
      $error("probes: expected %0d, got %0d", want.probes, got.probes);
      errors++;
    end
    if (got.key_count !== want.key_count) begin
      $error("key_count: expected %0d, got %0d", want.key_count, got.key_count);
      errors++;
    end
  endfunction

  function int unsigned outstanding();
    return pending_results.size();
  endfunction
endclass

module tb_linear_probe_hash_set;
  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  // longest request: divider, home fetch and a walk over every slot
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam logic [KEY_BITS-1:0] KEY_ALL_ONES = {KEY_BITS{1'b1}};

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     psel, penable, pwrite, pready;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata, prdata;

  lph_req_if req_if ();
  lph_rsp_if rsp_if ();

  hash_set_scoreboard  sb;
  bit                  no_idle = 1'b0;
  int unsigned         cycle_count = 0;
  logic [KEY_BITS-1:0] key_pool [$];

  linear_probe_hash_set uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, sb.outstanding());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Response side: check each beat, stall at random, one long hold-off.
  initial begin
    int unsigned holdoff_left = 0;
    int unsigned responses = 0;
    bit          holdoff_done = 1'b0;
    lph_result_t got;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got.found     = rsp_if.found;
        got.status    = status_e'(rsp_if.status);
        got.slot      = rsp_if.slot;
        got.probes    = rsp_if.probes;
        got.key_count = rsp_if.key_count;
        sb.check_response(got);
        responses++;
        if (responses == 150 && !holdoff_done) begin
          holdoff_left = 400;
          holdoff_done = 1'b1;
        end
      end
      if (rst_ni !== 1'b1) begin
        rsp_if.ready <= 1'b0;
      end else if (holdoff_left != 0) begin
        holdoff_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !(!no_idle && $urandom_range(99) < 6);
      end
    end
  end

  task automatic send_request(input logic op, input logic [KEY_BITS-1:0] key);
    if (!no_idle && $urandom_range(99) < 6) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.key       <= key;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_request(op, key);
    if (op == OP_INSERT && key != '0) key_pool.push_back(key);
  endtask

  // Drop valid and hold until every response is back.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic set_phase(input int unsigned tsize, input int unsigned maxk);
    drain();
    write_register(REG_TABLE_SIZE, APB_DATA_BITS'(tsize));
    write_register(REG_MAX_KEYS, APB_DATA_BITS'(maxk));
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    int unsigned         size, r, home;
    logic [KEY_BITS-1:0] k;
    size = sb.eff_size();
    r    = $urandom_range(99);
    if (r < 35 && key_pool.size() != 0) begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
    end else if (r < 40) begin
      k = '0;
    end else if (r < 45) begin
      case ($urandom_range(2))
        0:       k = KEY_ALL_ONES;
        1:       k = KEY_BITS'(1);
        default: k = KEY_BITS'(1) << $urandom_range(KEY_BITS - 1);
      endcase
    end else if (r < 70) begin
      // crowd a few home slots at both ends so chains collide and wrap
      home = $urandom_range(3);
      if ($urandom_range(1)) home = size - 1 - (home % size);
      home = home % size;
      k = KEY_BITS'(home + size * $urandom_range(0, (KEY_ALL_ONES - home) / size));
    end else begin
      k = KEY_BITS'($urandom());
    end
    return k;
  endfunction

  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_request(($urandom_range(99) < 55) ? OP_INSERT : OP_LOOKUP, pick_key());
    end
  endtask

  initial begin
    sb = new();
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_LOOKUP;
    req_if.key       <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizing: 1021 slots, so keys 5, 1026, 2047, 3068 share a home slot
    send_request(OP_LOOKUP, '0);
    send_request(OP_INSERT, '0);
    send_request(OP_LOOKUP, KEY_BITS'(5));
    send_request(OP_INSERT, KEY_BITS'(5));
    send_request(OP_INSERT, KEY_BITS'(5));
    send_request(OP_LOOKUP, KEY_BITS'(5));
    send_request(OP_INSERT, KEY_BITS'(1026));
    send_request(OP_INSERT, KEY_BITS'(2047));
    send_request(OP_LOOKUP, KEY_BITS'(2047));
    send_request(OP_LOOKUP, KEY_BITS'(3068));
    send_request(OP_INSERT, KEY_ALL_ONES);
    send_request(OP_LOOKUP, KEY_ALL_ONES);
    send_request(OP_INSERT, KEY_BITS'(1));
    // last slot, then chains that wrap past slot 0
    send_request(OP_INSERT, KEY_BITS'(1020));
    send_request(OP_INSERT, KEY_BITS'(2041));
    send_request(OP_INSERT, KEY_BITS'(3062));
    send_request(OP_LOOKUP, KEY_BITS'(3062));
    send_request(OP_INSERT, KEY_BITS'(31'h4000_0000));

    set_phase(2047, 1023);
    run_random(110);
    set_phase(0, 1);
    run_random(30);
    set_phase(97, 1023);
    run_random(70);
    drain();
    run_random(70);
    set_phase(127, 100);
    run_random(60);
    no_idle = 1'b1;
    set_phase(251, 1023);
    run_random(130);
    drain();
    no_idle = 1'b0;
    set_phase(3, 512);
    run_random(30);
    set_phase(1024, 300);
    run_random(180);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d lookups, %0d inserts: %0d hits, %0d stored, %0d duplicates, %0d full, %0d zero",
             sb.n_lookups, sb.n_inserts, sb.n_hits, sb.n_stored, sb.n_dup, sb.n_full,
             sb.n_zero);
    $display("table sizes 1 to 1024 slots, key limits 1 to 1023, %0d keys held, %0d cycles",
             sb.held, cycle_count);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/lph_pkg.sv
design/lph_if.sv
design/lph_cfg.sv
design/lph_mod.sv
design/lph_slot_mem.sv
design/linear_probe_hash_set.sv
dv/tb_linear_probe_hash_set.sv
